// ----- hw/rtl/spsz_pkg.sv -----
package spsz_pkg;

    localparam int MAX_LEADING_ZEROS = 31;
    localparam logic [7:0] EMU_PREVENT_BYTE = 8'h03;
    localparam logic [7:0] FIELD_SINK = 8'hFF;
    localparam logic [7:0] FIELD_EXPGOL = 8'h00;

    typedef enum logic [5:0] {
        STEP_HDR, STEP_PROFILE, STEP_CONSTR, STEP_LEVEL, STEP_SPSID, STEP_CHROMA,
        STEP_RCT, STEP_BDL, STEP_BDC, STEP_QPBYPASS, STEP_SCALING, STEP_SCLIST,
        STEP_LOG2FN, STEP_POCTYPE, STEP_POCLSB, STEP_DPOAZ, STEP_OFFNONREF,
        STEP_OFFTB, STEP_NUMCYC, STEP_OFFREF, STEP_NUMREF, STEP_GAPS, STEP_WMB,
        STEP_HMB, STEP_FMO, STEP_MBAFF, STEP_D8, STEP_CROP, STEP_CROPOFF,
        STEP_VUI, STEP_AR, STEP_ARIDC, STEP_SAR, STEP_OVS, STEP_OVSAPP, STEP_VST,
        STEP_VFMT, STEP_COLOUR, STEP_CHLOC, STEP_CHLOCV, STEP_TIMING, STEP_TICK,
        STEP_TSCALE, STEP_DONE, STEP_NOTSPS
    } step_t;

    typedef enum logic [2:0] {
        CTRL_IDLE, CTRL_SHIFT, CTRL_DSTART, CTRL_DIV, CTRL_FIN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        STATUS_NOT_SPS = 2'd0,
        STATUS_PARSED  = 2'd1,
        STATUS_SHORT   = 2'd2
    } status_t;

    typedef struct packed {
        step_t       step;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] tick;
        logic [31:0] tscale;
        logic        timing;
    } spsz_info_t;

    // field width of each step: 0 is an exp-golomb code, 0xff ignores bits
    function automatic logic [7:0] step_bits(step_t s);
        case (s)
            STEP_HDR, STEP_PROFILE, STEP_CONSTR, STEP_LEVEL, STEP_SCLIST,
            STEP_ARIDC:                                         step_bits = 8'd8;
            STEP_RCT, STEP_QPBYPASS, STEP_SCALING, STEP_DPOAZ, STEP_GAPS,
            STEP_FMO, STEP_MBAFF, STEP_D8, STEP_CROP, STEP_VUI, STEP_AR,
            STEP_OVS, STEP_OVSAPP, STEP_VST, STEP_CHLOC, STEP_TIMING: step_bits = 8'd1;
            STEP_SAR, STEP_TICK, STEP_TSCALE:                    step_bits = 8'd32;
            STEP_VFMT:                                          step_bits = 8'd5;
            STEP_COLOUR:                                        step_bits = 8'd24;
            STEP_DONE, STEP_NOTSPS:                             step_bits = FIELD_SINK;
            default:                                            step_bits = FIELD_EXPGOL;
        endcase
    endfunction

    function automatic logic [15:0] mbs_to_pixels(logic [31:0] v);
        if (v >= 32'd4095) begin
            mbs_to_pixels = 16'hFFFF;
        end else begin
            mbs_to_pixels = {v[11:0] + 12'd1, 4'd0};
        end
    endfunction

endpackage

// ----- hw/rtl/h264_sps_size_parser.sv -----
// channel  direction  tdata (low bit up)                                   tlast
// s_       in         data_byte[7:0]                                       last_byte
// m_       out        status[1:0] width[17:2] height[33:18] fps[64:34]     -
//                     fps_valid[65], zero fill to 72 bits
//
// a byte is taken in CTRL_IDLE, then CTRL_SHIFT shifts its bits into the parser while input waits
// a dropped emulation prevention byte is taken in CTRL_IDLE and is not shifted into the parser
// after the last byte come divider start, the serial fps divider and the result load
// reset is synchronous on aresetn low and clears parser, divider control and output valid
// a held result lets bytes in until the next unit's last byte, then input waits for the load
module h264_sps_size_parser
    import spsz_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // status, width, height, fps, fps_valid, zero fill
);

    ctrl_state_t state_reg, state_next;
    logic [7:0]  sh_reg, sh_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [1:0]  zr_reg, zr_next;
    logic        mv_reg, mv_next;
    logic [71:0] md_reg, md_next;

    logic        accept;
    logic        drop;
    logic        shift_en;
    logic        div_start;
    logic        load;
    logic        div_done;
    logic [30:0] quotient;
    spsz_info_t  info;
    status_t     status;
    logic        fps_ok;

    assign accept = s_tvalid && s_tready;
    assign drop   = (zr_reg == 2'd2) && (s_tdata == EMU_PREVENT_BYTE);

    spsz_bit_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (load),
        .bit_en  (shift_en),
        .bit_in  (sh_reg[7]),
        .info    (info)
    );

    spsz_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (info.tscale[31:1]),
        .divisor  (info.tick),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTRL_IDLE: begin
                if (accept) begin
                    if (!drop) begin
                        state_next = CTRL_SHIFT;
                    end else if (s_tlast) begin
                        state_next = CTRL_DSTART;
                    end
                end
            end
            CTRL_SHIFT: begin
                if (cnt_reg == 3'd7) begin
                    state_next = last_reg ? CTRL_DSTART : CTRL_IDLE;
                end
            end
            CTRL_DSTART: state_next = CTRL_DIV;
            CTRL_DIV: begin
                if (div_done) begin
                    state_next = CTRL_FIN;
                end
            end
            CTRL_FIN: begin
                if (!mv_reg || m_tready) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: state_next = CTRL_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        shift_en  = 1'b0;
        div_start = 1'b0;
        load      = 1'b0;
        case (state_reg)
            CTRL_IDLE:   s_tready  = 1'b1;
            CTRL_SHIFT:  shift_en  = 1'b1;
            CTRL_DSTART: div_start = 1'b1;
            CTRL_FIN:    load      = !mv_reg || m_tready;
            default: ;
        endcase
    end

    always_comb begin
        if (info.step == STEP_NOTSPS || info.step == STEP_HDR) begin
            status = STATUS_NOT_SPS;
        end else if (info.step == STEP_DONE) begin
            status = STATUS_PARSED;
        end else begin
            status = STATUS_SHORT;
        end
    end

    assign fps_ok = (status == STATUS_PARSED) && info.timing && (info.tick != 32'd0);

    always_comb begin
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        zr_next   = zr_reg;
        mv_next   = mv_reg;
        md_next   = md_reg;
        if (accept) begin
            sh_next   = s_tdata;
            cnt_next  = '0;
            last_next = s_tlast;
            if (drop) begin
                zr_next = '0;
            end else if (s_tdata == 8'd0) begin
                zr_next = (zr_reg < 2'd2) ? zr_reg + 2'd1 : 2'd2;
            end else begin
                zr_next = '0;
            end
        end
        if (shift_en) begin
            sh_next  = {sh_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
        end
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        if (load) begin
            mv_next = 1'b1;
            zr_next = '0;
            md_next = '0;
            md_next[1:0] = status;
            if (status != STATUS_NOT_SPS) begin
                md_next[17:2]  = info.width;
                md_next[33:18] = info.height;
            end
            if (fps_ok) begin
                md_next[64:34] = quotient;
                md_next[65]    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTRL_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            zr_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            zr_reg    <= zr_next;
            mv_reg    <= mv_next;
        end
        sh_reg <= sh_next;
        md_reg <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

// ----- hw/rtl/spsz_bit_parser.sv -----
module spsz_bit_parser
    import spsz_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       clear,
    input  logic       bit_en,
    input  logic       bit_in,
    output spsz_info_t info
);

    step_t       step_reg, step_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  bl_reg, bl_next;
    logic [5:0]  lz_reg, lz_next;
    logic        suffix_reg, suffix_next;
    logic [31:0] loop_reg, loop_next;
    logic [7:0]  profile_reg, profile_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] tscale_reg, tscale_next;
    logic        timing_reg, timing_next;

    logic [7:0]  fbits;
    logic [7:0]  nbits;
    logic        finish;
    logic [31:0] fv;
    logic [31:0] acc_shift;
    logic [31:0] loop_dec;
    step_t       nx;

    assign fbits     = step_bits(step_reg);
    assign acc_shift = {acc_reg[30:0], bit_in};
    assign loop_dec  = loop_reg - 32'd1;
    assign nbits     = step_bits(nx);

    always_comb begin
        step_next    = step_reg;
        acc_next     = acc_reg;
        bl_next      = bl_reg;
        lz_next      = lz_reg;
        suffix_next  = suffix_reg;
        loop_next    = loop_reg;
        profile_next = profile_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        tick_next    = tick_reg;
        tscale_next  = tscale_reg;
        timing_next  = timing_reg;
        finish       = 1'b0;
        fv           = '0;
        nx           = STEP_DONE;

        if (bit_en && fbits != FIELD_SINK) begin
            if (fbits != FIELD_EXPGOL) begin
                acc_next = acc_shift;
                bl_next  = bl_reg - 6'd1;
                if (bl_reg == 6'd1) begin
                    finish = 1'b1;
                    fv     = acc_shift;
                end
            end else if (!suffix_reg) begin
                if (!bit_in) begin
                    if (lz_reg < 6'(MAX_LEADING_ZEROS)) begin
                        lz_next = lz_reg + 6'd1;
                    end
                end else if (lz_reg == 6'd0) begin
                    finish = 1'b1;
                end else begin
                    suffix_next = 1'b1;
                    bl_next     = lz_reg;
                    acc_next    = '0;
                end
            end else begin
                acc_next = acc_shift;
                bl_next  = bl_reg - 6'd1;
                if (bl_reg == 6'd1) begin
                    finish = 1'b1;
                    fv     = ((32'd1 << lz_reg[4:0]) - 32'd1) + acc_shift;
                end
            end
        end

        if (finish) begin
            case (step_reg)
                STEP_HDR:      nx = (fv[4:0] == 5'd7) ? STEP_PROFILE : STEP_NOTSPS;
                STEP_PROFILE: begin
                    profile_next = fv[7:0];
                    nx = STEP_CONSTR;
                end
                STEP_CONSTR:   nx = STEP_LEVEL;
                STEP_LEVEL:    nx = STEP_SPSID;
                STEP_SPSID:    nx = (profile_reg == 8'd100 || profile_reg == 8'd110 ||
                                     profile_reg == 8'd122 || profile_reg == 8'd144)
                                    ? STEP_CHROMA : STEP_LOG2FN;
                STEP_CHROMA:   nx = (fv == 32'd3) ? STEP_RCT : STEP_BDL;
                STEP_RCT:      nx = STEP_BDL;
                STEP_BDL:      nx = STEP_BDC;
                STEP_BDC:      nx = STEP_QPBYPASS;
                STEP_QPBYPASS: nx = STEP_SCALING;
                STEP_SCALING:  nx = (fv != 32'd0) ? STEP_SCLIST : STEP_LOG2FN;
                STEP_SCLIST:   nx = STEP_LOG2FN;
                STEP_LOG2FN:   nx = STEP_POCTYPE;
                STEP_POCTYPE:  nx = (fv == 32'd0) ? STEP_POCLSB :
                                    ((fv == 32'd1) ? STEP_DPOAZ : STEP_NUMREF);
                STEP_POCLSB:   nx = STEP_NUMREF;
                STEP_DPOAZ:    nx = STEP_OFFNONREF;
                STEP_OFFNONREF: nx = STEP_OFFTB;
                STEP_OFFTB:    nx = STEP_NUMCYC;
                STEP_NUMCYC: begin
                    loop_next = fv;
                    nx = (fv == 32'd0) ? STEP_NUMREF : STEP_OFFREF;
                end
                STEP_OFFREF: begin
                    loop_next = loop_dec;
                    nx = (loop_dec == 32'd0) ? STEP_NUMREF : STEP_OFFREF;
                end
                STEP_NUMREF:   nx = STEP_GAPS;
                STEP_GAPS:     nx = STEP_WMB;
                STEP_WMB: begin
                    width_next = mbs_to_pixels(fv);
                    nx = STEP_HMB;
                end
                STEP_HMB: begin
                    height_next = mbs_to_pixels(fv);
                    nx = STEP_FMO;
                end
                STEP_FMO:      nx = (fv != 32'd0) ? STEP_D8 : STEP_MBAFF;
                STEP_MBAFF:    nx = STEP_D8;
                STEP_D8:       nx = STEP_CROP;
                STEP_CROP: begin
                    if (fv != 32'd0) begin
                        loop_next = 32'd4;
                        nx = STEP_CROPOFF;
                    end else begin
                        nx = STEP_VUI;
                    end
                end
                STEP_CROPOFF: begin
                    loop_next = loop_dec;
                    nx = (loop_dec == 32'd0) ? STEP_VUI : STEP_CROPOFF;
                end
                STEP_VUI:      nx = (fv != 32'd0) ? STEP_AR : STEP_DONE;
                STEP_AR:       nx = (fv != 32'd0) ? STEP_ARIDC : STEP_OVS;
                STEP_ARIDC:    nx = (fv == 32'd255) ? STEP_SAR : STEP_OVS;
                STEP_SAR:      nx = STEP_OVS;
                STEP_OVS:      nx = (fv != 32'd0) ? STEP_OVSAPP : STEP_VST;
                STEP_OVSAPP:   nx = STEP_VST;
                STEP_VST:      nx = (fv != 32'd0) ? STEP_VFMT : STEP_CHLOC;
                STEP_VFMT:     nx = fv[0] ? STEP_COLOUR : STEP_CHLOC;
                STEP_COLOUR:   nx = STEP_CHLOC;
                STEP_CHLOC: begin
                    if (fv != 32'd0) begin
                        loop_next = 32'd2;
                        nx = STEP_CHLOCV;
                    end else begin
                        nx = STEP_TIMING;
                    end
                end
                STEP_CHLOCV: begin
                    loop_next = loop_dec;
                    nx = (loop_dec == 32'd0) ? STEP_TIMING : STEP_CHLOCV;
                end
                STEP_TIMING:   nx = (fv != 32'd0) ? STEP_TICK : STEP_DONE;
                STEP_TICK: begin
                    tick_next = fv;
                    nx = STEP_TSCALE;
                end
                STEP_TSCALE: begin
                    tscale_next = fv;
                    timing_next = 1'b1;
                    nx = STEP_DONE;
                end
                default:       nx = STEP_DONE;
            endcase
            step_next   = nx;
            acc_next    = '0;
            lz_next     = '0;
            suffix_next = 1'b0;
            bl_next     = (nbits == FIELD_SINK) ? 6'd0 : nbits[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            step_reg    <= STEP_HDR;
            acc_reg     <= '0;
            bl_reg      <= 6'd8;
            lz_reg      <= '0;
            suffix_reg  <= 1'b0;
            loop_reg    <= '0;
            profile_reg <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            tick_reg    <= '0;
            tscale_reg  <= '0;
            timing_reg  <= 1'b0;
        end else begin
            step_reg    <= step_next;
            acc_reg     <= acc_next;
            bl_reg      <= bl_next;
            lz_reg      <= lz_next;
            suffix_reg  <= suffix_next;
            loop_reg    <= loop_next;
            profile_reg <= profile_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            tick_reg    <= tick_next;
            tscale_reg  <= tscale_next;
            timing_reg  <= timing_next;
        end
    end

    assign info.step   = step_reg;
    assign info.width  = width_reg;
    assign info.height = height_reg;
    assign info.tick   = tick_reg;
    assign info.tscale = tscale_reg;
    assign info.timing = timing_reg;

endmodule

// ----- hw/rtl/spsz_divider.sv -----
module spsz_divider
    import spsz_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [30:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [30:0] q_reg, q_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, q_reg[30]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            q_next   = {q_reg[29:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- tb/sv/sps_size_checker.sv -----
`timescale 1ns / 1ps
module sps_size_checker
    import spsz_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          report_count,
    output int          parsed_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] width;
        logic [15:0] height;
        logic [30:0] fps;
        logic        fps_valid;
    } sps_report_t;

    sps_report_t expected_reports[$];

    // parser state mirror
    step_t       step;
    int unsigned zrun, lzeros, bits_left, loop_left;
    logic [31:0] acc, tick, tscale;
    logic [7:0]  profile;
    logic [15:0] wpix, hpix;
    logic        timing, suffix;

    function automatic int unsigned field_width(step_t s);
        case (s)
            STEP_HDR, STEP_PROFILE, STEP_CONSTR, STEP_LEVEL, STEP_SCLIST, STEP_ARIDC:
                return 8;
            STEP_RCT, STEP_QPBYPASS, STEP_SCALING, STEP_DPOAZ, STEP_GAPS, STEP_FMO,
            STEP_MBAFF, STEP_D8, STEP_CROP, STEP_VUI, STEP_AR, STEP_OVS, STEP_OVSAPP,
            STEP_VST, STEP_CHLOC, STEP_TIMING:
                return 1;
            STEP_SAR, STEP_TICK, STEP_TSCALE: return 32;
            STEP_VFMT: return 5;
            STEP_COLOUR: return 24;
            STEP_DONE, STEP_NOTSPS: return 255;
            default: return 0;
        endcase
    endfunction

    function automatic logic [15:0] to_pixels(logic [31:0] v);
        longint unsigned p;
        p = (longint'(v) + 1) * 16;
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic void enter_step(step_t s);
        int unsigned fw;
        fw = field_width(s);
        step = s;
        acc = 0;
        lzeros = 0;
        suffix = 1'b0;
        bits_left = (fw == 255) ? 0 : fw;
    endfunction

    function automatic void clear_parser();
        zrun = 0; loop_left = 0; profile = 0; wpix = 0; hpix = 0;
        tick = 0; tscale = 0; timing = 1'b0;
        enter_step(STEP_HDR);
    endfunction

    function automatic void close_field(logic [31:0] v);
        step_t nx;
        case (step)
            STEP_HDR: nx = (v[4:0] == 5'd7) ? STEP_PROFILE : STEP_NOTSPS;
            STEP_PROFILE: begin profile = v[7:0]; nx = STEP_CONSTR; end
            STEP_CONSTR: nx = STEP_LEVEL;
            STEP_LEVEL: nx = STEP_SPSID;
            STEP_SPSID: nx = (profile == 100 || profile == 110 || profile == 122 ||
                              profile == 144) ? STEP_CHROMA : STEP_LOG2FN;
            STEP_CHROMA: nx = (v == 3) ? STEP_RCT : STEP_BDL;
            STEP_RCT: nx = STEP_BDL;
            STEP_BDL: nx = STEP_BDC;
            STEP_BDC: nx = STEP_QPBYPASS;
            STEP_QPBYPASS: nx = STEP_SCALING;
            STEP_SCALING: nx = (v != 0) ? STEP_SCLIST : STEP_LOG2FN;
            STEP_SCLIST: nx = STEP_LOG2FN;
            STEP_LOG2FN: nx = STEP_POCTYPE;
            STEP_POCTYPE: nx = (v == 0) ? STEP_POCLSB : (v == 1) ? STEP_DPOAZ : STEP_NUMREF;
            STEP_POCLSB: nx = STEP_NUMREF;
            STEP_DPOAZ: nx = STEP_OFFNONREF;
            STEP_OFFNONREF: nx = STEP_OFFTB;
            STEP_OFFTB: nx = STEP_NUMCYC;
            STEP_NUMCYC: begin
                loop_left = v;
                nx = (v == 0) ? STEP_NUMREF : STEP_OFFREF;
            end
            STEP_OFFREF: begin
                loop_left--;
                nx = (loop_left == 0) ? STEP_NUMREF : STEP_OFFREF;
            end
            STEP_NUMREF: nx = STEP_GAPS;
            STEP_GAPS: nx = STEP_WMB;
            STEP_WMB: begin wpix = to_pixels(v); nx = STEP_HMB; end
            STEP_HMB: begin hpix = to_pixels(v); nx = STEP_FMO; end
            STEP_FMO: nx = (v != 0) ? STEP_D8 : STEP_MBAFF;
            STEP_MBAFF: nx = STEP_D8;
            STEP_D8: nx = STEP_CROP;
            STEP_CROP: begin
                if (v != 0) begin loop_left = 4; nx = STEP_CROPOFF; end
                else nx = STEP_VUI;
            end
            STEP_CROPOFF: begin
                loop_left--;
                nx = (loop_left == 0) ? STEP_VUI : STEP_CROPOFF;
            end
            STEP_VUI: nx = (v != 0) ? STEP_AR : STEP_DONE;
            STEP_AR: nx = (v != 0) ? STEP_ARIDC : STEP_OVS;
            STEP_ARIDC: nx = (v == 255) ? STEP_SAR : STEP_OVS;
            STEP_SAR: nx = STEP_OVS;
            STEP_OVS: nx = (v != 0) ? STEP_OVSAPP : STEP_VST;
            STEP_OVSAPP: nx = STEP_VST;
            STEP_VST: nx = (v != 0) ? STEP_VFMT : STEP_CHLOC;
            STEP_VFMT: nx = v[0] ? STEP_COLOUR : STEP_CHLOC;
            STEP_COLOUR: nx = STEP_CHLOC;
            STEP_CHLOC: begin
                if (v != 0) begin loop_left = 2; nx = STEP_CHLOCV; end
                else nx = STEP_TIMING;
            end
            STEP_CHLOCV: begin
                loop_left--;
                nx = (loop_left == 0) ? STEP_TIMING : STEP_CHLOCV;
            end
            STEP_TIMING: nx = (v != 0) ? STEP_TICK : STEP_DONE;
            STEP_TICK: begin tick = v; nx = STEP_TSCALE; end
            STEP_TSCALE: begin tscale = v; timing = 1'b1; nx = STEP_DONE; end
            default: nx = STEP_DONE;
        endcase
        enter_step(nx);
    endfunction

    function automatic void shift_bit(logic b);
        int unsigned fw;
        logic [32:0] val;
        fw = field_width(step);
        if (fw == 255) return;
        if (fw != 0) begin
            acc = {acc[30:0], b};
            bits_left--;
            if (bits_left == 0) close_field(acc);
            return;
        end
        if (!suffix) begin
            if (!b) begin
                if (lzeros < MAX_LEADING_ZEROS) lzeros++;
            end else if (lzeros == 0) begin
                close_field(32'd0);
            end else begin
                suffix = 1'b1;
                bits_left = lzeros;
                acc = 0;
            end
            return;
        end
        acc = {acc[30:0], b};
        bits_left--;
        if (bits_left == 0) begin
            val = (33'd1 << lzeros[4:0]) - 33'd1 + {1'b0, acc};
            close_field(val[31:0]);
        end
    endfunction

    function automatic void take_byte(logic [7:0] d, logic last);
        sps_report_t r;
        if (zrun == 2 && d == EMU_PREVENT_BYTE) begin
            zrun = 0;
        end else begin
            for (int i = 7; i >= 0; i--) shift_bit(d[i]);
            zrun = (d == 0) ? ((zrun < 2) ? zrun + 1 : 2) : 0;
        end
        if (!last) return;
        r = '0;
        if (step == STEP_NOTSPS || step == STEP_HDR) begin
            r.status = STATUS_NOT_SPS;
        end else begin
            r.status = (step == STEP_DONE) ? STATUS_PARSED : STATUS_SHORT;
            r.width = wpix;
            r.height = hpix;
            if (step == STEP_DONE && timing && tick != 0) begin
                r.fps = 31'(64'(tscale) / (64'(tick) * 2));
                r.fps_valid = 1'b1;
            end
        end
        expected_reports.push_back(r);
        clear_parser();
    endfunction

    always @(posedge aclk) begin
        sps_report_t want;
        sps_report_t got;
        if (!aresetn) begin
            expected_reports.delete();
            clear_parser();
            fail_count <= 0;
            report_count <= 0;
            parsed_count <= 0;
        end else begin
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.width = m_tdata[17:2];
                got.height = m_tdata[33:18];
                got.fps = m_tdata[64:34];
                got.fps_valid = m_tdata[65];
                report_count <= report_count + 1;
                if (got.status == STATUS_PARSED) parsed_count <= parsed_count + 1;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected report status=%0d w=%0d h=%0d fps=%0d v=%0d",
                             $time, got.status, got.width, got.height, got.fps,
                             got.fps_valid);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_reports.pop_front();
                    if (got != want) begin
                        $display("%0t: expected status=%0d w=%0d h=%0d fps=%0d v=%0d",
                                 $time, want.status, want.width, want.height, want.fps,
                                 want.fps_valid);
                        $display("%0t:   actual status=%0d w=%0d h=%0d fps=%0d v=%0d",
                                 $time, got.status, got.width, got.height, got.fps,
                                 got.fps_valid);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending_count = expected_reports.size();

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import spsz_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    int          fail_count, pending_count, report_count, parsed_count;

    bit          calm;        // no idling on either side
    int          rx_holdoff;  // cycles the receiver still refuses
    int          hold_reqs;   // holdoff requests from the stimulus
    int          hold_seen;   // holdoff requests already taken
    int          byte_count;

    // bit writer for building nal units
    logic [7:0]  nal[$];
    logic [7:0]  cur_byte;
    int          cur_bits, zeros_out;

    h264_sps_size_parser u_dut (.*);

    sps_size_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .report_count(report_count), .parsed_count(parsed_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_holdoff <= 0;
            hold_seen <= hold_reqs;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            rx_holdoff <= 3000;
            m_tready <= 1'b0;
        end else if (rx_holdoff > 0) begin
            rx_holdoff <= rx_holdoff - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 29);
        end
    end

    // bytes are written with emulation prevention like an encoder would
    task automatic emit_byte(logic [7:0] b);
        if (zeros_out >= 2 && b <= 8'h03) begin
            nal.push_back(EMU_PREVENT_BYTE);
            zeros_out = 0;
        end
        nal.push_back(b);
        zeros_out = (b == 0) ? zeros_out + 1 : 0;
    endtask

    task automatic put_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--) begin
            cur_byte = {cur_byte[6:0], v[i]};
            cur_bits++;
            if (cur_bits == 8) begin
                emit_byte(cur_byte);
                cur_bits = 0;
            end
        end
    endtask

    task automatic put_ue(logic [31:0] v);
        logic [32:0] x;
        int n;
        x = {1'b0, v} + 33'd1;
        n = 0;
        for (int i = 32; i >= 0; i--) if (x[i] && n == 0) n = i;
        put_bits(32'd0, n);
        // a 33-bit code word does not fit the writer in one piece
        if (n == 32) begin
            put_bits(32'd1, 1);
            put_bits(32'd0, 32);
        end else begin
            put_bits(x[31:0], n + 1);
        end
    endtask

    task automatic begin_nal();
        nal.delete();
        cur_bits = 0;
        zeros_out = 0;
        cur_byte = 0;
    endtask

    task automatic finish_nal();
        put_bits(32'd1, 1);
        while (cur_bits != 0) put_bits(32'd0, 1);
    endtask

    function automatic logic [31:0] rand_ue();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(2000, 4200);
            2: return $urandom;
            default: return $urandom_range(15);
        endcase
    endfunction

    // writes a well-formed sps with random content
    task automatic build_sps(int profile_sel, bit with_vui, bit with_timing);
        logic [7:0] prof;
        int poc, n;
        case (profile_sel)
            0: prof = 8'd66;
            1: prof = 8'd100;
            2: prof = 8'd110;
            3: prof = 8'd122;
            4: prof = 8'd144;
            default: prof = 8'($urandom);
        endcase
        begin_nal();
        put_bits(32'({3'($urandom_range(3)), 5'd7}), 8);
        put_bits(32'(prof), 8);
        put_bits($urandom, 8);
        put_bits($urandom, 8);
        put_ue($urandom_range(31));
        if (prof == 100 || prof == 110 || prof == 122 || prof == 144) begin
            n = $urandom_range(3);
            put_ue(n);
            if (n == 3) put_bits($urandom, 1);
            put_ue($urandom_range(6));
            put_ue($urandom_range(6));
            put_bits($urandom, 1);
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n) put_bits($urandom, 8);
        end
        put_ue($urandom_range(12));
        poc = $urandom_range(2);
        put_ue(poc);
        if (poc == 0) put_ue($urandom_range(12));
        else if (poc == 1) begin
            put_bits($urandom, 1);
            put_ue(rand_ue());
            put_ue(rand_ue());
            n = $urandom_range(4);
            put_ue(n);
            repeat (n) put_ue($urandom_range(40));
        end
        put_ue($urandom_range(16));
        put_bits($urandom, 1);
        put_ue(rand_ue());
        put_ue(rand_ue());
        n = $urandom_range(1);
        put_bits(n, 1);
        if (!n) put_bits($urandom, 1);
        put_bits($urandom, 1);
        n = $urandom_range(1);
        put_bits(n, 1);
        if (n) repeat (4) put_ue($urandom_range(20));
        put_bits(32'(with_vui), 1);
        if (with_vui) begin
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n) begin
                n = ($urandom_range(1)) ? 255 : $urandom_range(254);
                put_bits(n, 8);
                if (n == 255) put_bits($urandom, 32);
            end
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n) put_bits($urandom, 1);
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n) begin
                n = $urandom_range(31);
                put_bits(n, 5);
                if (n & 1) put_bits($urandom, 24);
            end
            n = $urandom_range(1);
            put_bits(n, 1);
            if (n) repeat (2) put_ue($urandom_range(5));
            put_bits(32'(with_timing), 1);
            if (with_timing) begin
                case ($urandom_range(4))
                    0: put_bits(32'd0, 32);
                    1: put_bits($urandom, 32);
                    2: put_bits(32'hFFFF_FFFF, 32);
                    default: put_bits($urandom_range(1, 2000), 32);
                endcase
                put_bits(($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom, 32);
            end
        end
        finish_nal();
    endtask

    task automatic send_byte(logic [7:0] d, logic last);
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        byte_count++;
    endtask

    // sends the queue as one nal unit, optionally cut short
    task automatic send_nal(int cut);
        int n;
        n = nal.size();
        if (cut > 0 && cut < n) n = cut;
        for (int i = 0; i < n; i++) send_byte(nal[i], i == n - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        calm = 1'b0;
        byte_count = 0;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single byte units, extremes, not-sps header, stray 0x03
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h67, 1'b1);
        send_byte(8'h65, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h67, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b1);
        // long exp-golomb prefix saturates
        send_byte(8'h67, 1'b0);
        send_byte(8'h42, 1'b0);
        repeat (6) send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        // complete units of each profile branch
        for (int p = 0; p < 5; p++) begin
            build_sps(p, 1'b1, 1'b1);
            send_nal(0);
        end
        build_sps(1, 1'b0, 1'b0);
        send_nal(0);
        build_sps(0, 1'b1, 1'b0);
        send_nal(0);
        wait_drained();

        // receiver holds off while bytes keep flowing
        hold_reqs++;
        for (int k = 0; k < 4; k++) begin
            build_sps($urandom_range(5), 1'b1, 1'b1);
            send_nal(0);
        end
        wait_drained();

        while (byte_count < 1450) begin
            if ($urandom_range(99) < 10) calm = ~calm;
            case ($urandom_range(9))
                0: begin
                    begin_nal();
                    repeat ($urandom_range(1, 12)) emit_byte(8'($urandom));
                    send_nal(0);
                end
                1: begin
                    build_sps($urandom_range(5), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                    send_nal($urandom_range(1, nal.size()));
                end
                default: begin
                    build_sps($urandom_range(5), $urandom_range(3) != 0,
                              $urandom_range(3) != 0);
                    send_nal(0);
                end
            endcase
            if ($urandom_range(29) == 0) wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        $display("sent %0d bytes, checked %0d reports (%0d fully parsed)",
                 byte_count, report_count, parsed_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
